// ----- design/irs_pkg.sv -----
// ----------------------------------------------------------------------------
// irs_pkg: shared types and constants of the index rank sorter
// Capacity, field widths and the link carried between neighbouring cells.
// ----------------------------------------------------------------------------
package irs_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int TAG_W     = 6;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic [TAG_W-1:0]        tag_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // What a cell shows its neighbours: its entry, and whether the key being
  // inserted ranks ahead of that entry.
  typedef struct packed {
    logic valid;
    key_t key;
    tag_t tag;
    logic place;
  } cell_link_t;

endpackage

// ----- design/irs_cell.sv -----
// ----------------------------------------------------------------------------
// irs_cell: one slot of the insertion chain
// Holds one (key, tag) entry. On insert it keeps its entry, takes the new
// one, or takes its left neighbour's; on drain it takes its right neighbour's.
// ----------------------------------------------------------------------------
module irs_cell import irs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       ins,
  input  logic       shift,
  input  key_t       new_key,
  input  tag_t       new_tag,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic valid;
  key_t key;
  tag_t tag;
  logic place;

  // strict compare keeps equal keys in arrival order
  assign place = !valid || (new_key < key);

  assign link = '{valid: valid, key: key, tag: tag, place: place};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins) begin
      if (left.place) begin
        valid <= left.valid;
      end else if (place) begin
        valid <= 1'b1;
      end
    end else if (shift) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      if (left.place) begin
        key <= left.key;
        tag <= left.tag;
      end else if (place) begin
        key <= new_key;
        tag <= new_tag;
      end
    end else if (shift) begin
      key <= right.key;
      tag <= right.tag;
    end
  end

endmodule

// ----- design/irs_chain.sv -----
// ----------------------------------------------------------------------------
// irs_chain: row of insertion cells
// Keeps its entries sorted by ascending key, ties in arrival order; the head
// cell holds the first entry and the row shifts towards it on drain.
// ----------------------------------------------------------------------------
module irs_chain import irs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic ins,
  input  logic shift,
  input  key_t new_key,
  input  tag_t new_tag,
  output tag_t head_tag
);

  cell_link_t links [MAX_ITEMS];
  cell_link_t lefts [MAX_ITEMS];
  cell_link_t rights[MAX_ITEMS];

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign lefts[i] = '0;
      end else begin : g_mid_l
        assign lefts[i] = links[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
        assign rights[i] = '0;
      end else begin : g_mid_r
        assign rights[i] = links[i+1];
      end

      irs_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ins     (ins),
        .shift   (shift),
        .new_key (new_key),
        .new_tag (new_tag),
        .left    (lefts[i]),
        .right   (rights[i]),
        .link    (links[i])
      );
    end
  endgenerate

  assign head_tag = links[0].tag;

endmodule

// ----- design/index_rank_sorter.sv -----
// ----------------------------------------------------------------------------
// index_rank_sorter: stable argsort of tags by signed key
// After the last item of a set the row drains into a registered output.
// Throughput: one item a cycle while loading, then one result a cycle while
// draining the cell row and not stalled; no item is taken during a drain.
// Reset: sync, active high; empties the row, clears count, flag and order bit.
// ----------------------------------------------------------------------------
module index_rank_sorter import irs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  tag_t tag,
  input  key_t key,
  input  logic last_item,
  output logic out_valid,
  input  logic out_stall,
  output tag_t sorted_tag,
  output logic last_result,
  output logic overflowed
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state;
  logic   sort_descending;
  cnt_t   item_count;
  logic   overflow_flag;
  cnt_t   remaining;
  logic   set_overflow;

  logic   accept;
  logic   has_room;
  logic   ins;
  logic   load_out;
  tag_t   head_asc;
  tag_t   head_desc;

  assign in_stall = (state != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign has_room = (item_count < cnt_t'(MAX_ITEMS));
  assign ins      = accept && has_room;
  assign load_out = (state == ST_DRAIN) && (remaining != '0) && (!out_valid || !out_stall);

  // one row sorts on the key, the other on its complement for descending order
  irs_chain u_asc (
    .clk      (clk),
    .rst      (rst),
    .ins      (ins),
    .shift    (load_out),
    .new_key  (key),
    .new_tag  (tag),
    .head_tag (head_asc)
  );

  irs_chain u_desc (
    .clk      (clk),
    .rst      (rst),
    .ins      (ins),
    .shift    (load_out),
    .new_key  (~key),
    .new_tag  (tag),
    .head_tag (head_desc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_descending <= 1'b0;
    end else if (cfg_write) begin
      sort_descending <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      item_count    <= '0;
      overflow_flag <= 1'b0;
      remaining     <= '0;
      set_overflow  <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (last_item) begin
              state         <= ST_DRAIN;
              remaining     <= item_count + cnt_t'(has_room);
              set_overflow  <= overflow_flag || !has_room;
              item_count    <= '0;
              overflow_flag <= 1'b0;
            end else if (has_room) begin
              item_count <= item_count + cnt_t'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (load_out) begin
            remaining <= remaining - cnt_t'(1);
            if (remaining == cnt_t'(1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sorted_tag  <= sort_descending ? head_desc : head_asc;
      last_result <= (remaining == cnt_t'(1));
      overflowed  <= set_overflow;
    end
  end

endmodule
